// File: rtl/core/dfrd_pkg.sv
package dfrd_pkg;

  // Hash word and serial digit geometry
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned NUM_DIGITS = HASH_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MIX_SHIFT  = 31;

  // Initial values and multipliers of the two chained hashes
  localparam logic [HASH_W-1:0] FIRST_INIT  = 64'hCBF29CE484222325;
  localparam logic [HASH_W-1:0] SECOND_INIT = 64'h9E3779B97F4A7C15;
  localparam logic [HASH_W-1:0] FIRST_MUL   = 64'h00000100000001B3;
  localparam logic [HASH_W-1:0] SECOND_MUL  = 64'hBF58476D1CE4E5B9;
  localparam logic [BYTE_W-1:0] SKIP_RESET  = 8'd16;

  // Which constant the serial multiplier works with
  typedef enum logic {
    MUL_FIRST  = 1'b0,
    MUL_SECOND = 1'b1
  } mul_sel_e;

  // Input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [HASH_W-1:0] full_first_hash;
    logic [HASH_W-1:0] full_second_hash;
    logic [HASH_W-1:0] tail_first_hash;
    logic [HASH_W-1:0] tail_second_hash;
  } out_item_t;

  // Control from the top level to one hash lane
  typedef struct packed {
    logic              start;
    logic              absorb;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } lane_req_t;

endpackage

// File: rtl/core/dfrd_mul.sv
// Digit-serial multiplier modulo 2^64 by one of two fixed constants.
// One 8-bit digit of the constant per cycle; the operand shifts left.
module dfrd_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  dfrd_pkg::mul_sel_e            sel_i,
  input  logic [dfrd_pkg::HASH_W-1:0]   opnd_i,
  output logic                          done_o,
  output logic [dfrd_pkg::HASH_W-1:0]   prod_o
);

  logic                                         run_q;
  logic                                         done_q;
  logic [dfrd_pkg::CNT_W-1:0]                   cnt_q;
  logic [dfrd_pkg::HASH_W-1:0]                  a_sh_q;
  logic [dfrd_pkg::HASH_W-1:0]                  c_sh_q;
  logic [dfrd_pkg::HASH_W-1:0]                  acc_q;
  logic [dfrd_pkg::HASH_W+dfrd_pkg::DIGIT_W-1:0] part;
  logic                                         last_digit;

  // Partial product of the operand and the current constant digit
  assign part       = a_sh_q * c_sh_q[dfrd_pkg::DIGIT_W-1:0];
  assign last_digit = (cnt_q == dfrd_pkg::CNT_W'(dfrd_pkg::NUM_DIGITS - 1));

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_digit) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift registers and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_sh_q <= opnd_i;
      c_sh_q <= (sel_i == dfrd_pkg::MUL_FIRST) ? dfrd_pkg::FIRST_MUL : dfrd_pkg::SECOND_MUL;
      acc_q  <= '0;
    end else if (run_q) begin
      acc_q  <= acc_q + part[dfrd_pkg::HASH_W-1:0];
      a_sh_q <= a_sh_q << dfrd_pkg::DIGIT_W;
      c_sh_q <= c_sh_q >> dfrd_pkg::DIGIT_W;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/core/dfrd_lane.sv
// One hash pair: FNV-1a step, then the chained mixer step, on a shared
// serial multiplier.
module dfrd_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dfrd_pkg::lane_req_t           req_i,
  output logic                          done_o,
  output logic [dfrd_pkg::HASH_W-1:0]   first_o,
  output logic [dfrd_pkg::HASH_W-1:0]   second_o
);

  typedef enum logic [2:0] {
    LN_IDLE   = 3'b001,
    LN_FIRST  = 3'b010,
    LN_SECOND = 3'b100
  } lane_state_e;

  lane_state_e                     st_q, st_d;
  logic [dfrd_pkg::HASH_W-1:0]     h0_q, h1_q;
  logic [dfrd_pkg::BYTE_W-1:0]     b_q;
  logic                            absorb_q;
  logic                            done_q;

  logic                            mul_start;
  dfrd_pkg::mul_sel_e              mul_sel;
  logic [dfrd_pkg::HASH_W-1:0]     mul_opnd;
  logic                            mul_done;
  logic [dfrd_pkg::HASH_W-1:0]     mul_prod;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      LN_IDLE:   if (req_i.start) st_d = LN_FIRST;
      LN_FIRST:  if (mul_done)    st_d = LN_SECOND;
      LN_SECOND: if (mul_done)    st_d = LN_IDLE;
      default:   st_d = LN_IDLE;
    endcase
  end

  // Multiplier operand: h0 ^ b first, then h1 + ((a >> 31) ^ b)
  always_comb begin
    mul_start = 1'b0;
    mul_sel   = dfrd_pkg::MUL_FIRST;
    mul_opnd  = h0_q ^ dfrd_pkg::HASH_W'(req_i.data);
    if (st_q == LN_IDLE) begin
      mul_start = req_i.start;
    end else if (st_q == LN_FIRST) begin
      mul_start = mul_done;
      mul_sel   = dfrd_pkg::MUL_SECOND;
      mul_opnd  = h1_q + ((mul_prod >> dfrd_pkg::MIX_SHIFT) ^ dfrd_pkg::HASH_W'(b_q));
    end
  end

  // State, hashes and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= LN_IDLE;
      done_q <= 1'b0;
      h0_q   <= dfrd_pkg::FIRST_INIT;
      h1_q   <= dfrd_pkg::SECOND_INIT;
    end else begin
      st_q   <= st_d;
      done_q <= 1'b0;
      if (st_q == LN_IDLE && req_i.clear) begin
        h0_q <= dfrd_pkg::FIRST_INIT;
        h1_q <= dfrd_pkg::SECOND_INIT;
      end
      if (st_q == LN_FIRST && mul_done && absorb_q) begin
        h0_q <= mul_prod;
      end
      if (st_q == LN_SECOND && mul_done) begin
        done_q <= 1'b1;
        if (absorb_q) begin
          h1_q <= mul_prod;
        end
      end
    end
  end

  // Byte and absorb flag of the transaction in progress
  always_ff @(posedge clk_i) begin
    if (st_q == LN_IDLE && req_i.start) begin
      b_q      <= req_i.data;
      absorb_q <= req_i.absorb;
    end
  end

  dfrd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .sel_i   (mul_sel),
    .opnd_i  (mul_opnd),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign done_o   = done_q;
  assign first_o  = h0_q;
  assign second_o = h1_q;

endmodule

// File: rtl/core/dual_fnv_range_digest_top.sv
// Each accepted byte runs two multiplies, the FNV-1a step and then the mixer
// step, one after the other on a serial 64x8 multiplier per hash pair; the next
// byte is taken only once both multiplies of the current byte are done.
// The output register lets the next byte be taken while a result waits.
// Reset (asynchronous, active low): hashes to their initial values, byte count
// to zero, skip count to 16, no result pending.
module dual_fnv_range_digest_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dfrd_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dfrd_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [dfrd_pkg::BYTE_W-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    TS_IDLE = 3'b001,
    TS_BUSY = 3'b010,
    TS_HOLD = 3'b100
  } top_state_e;

  top_state_e                    st_q, st_d;
  logic [dfrd_pkg::BYTE_W-1:0]   skip_q;
  logic [dfrd_pkg::BYTE_W-1:0]   seen_q;
  logic                          last_q;
  logic                          out_valid_q;
  dfrd_pkg::out_item_t           out_q;

  logic                          in_acc;
  logic                          out_acc;
  logic                          skipping;
  logic                          capture;
  dfrd_pkg::lane_req_t           full_req, tail_req;
  logic                          full_done, tail_done;
  logic [dfrd_pkg::HASH_W-1:0]   full_first, full_second;
  logic [dfrd_pkg::HASH_W-1:0]   tail_first, tail_second;

  assign in_ready_o = (st_q == TS_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_acc    = out_valid_q & out_ready_i;
  assign skipping   = (seen_q < skip_q);

  // Result capture into the output register, once it is free
  always_comb begin
    st_d    = st_q;
    capture = 1'b0;
    case (st_q)
      TS_IDLE: if (in_acc) st_d = TS_BUSY;
      TS_BUSY: begin
        if (full_done) begin
          if (!last_q) begin
            st_d = TS_IDLE;
          end else if (!out_valid_q || out_ready_i) begin
            capture = 1'b1;
            st_d    = TS_IDLE;
          end else begin
            st_d = TS_HOLD;
          end
        end
      end
      TS_HOLD: begin
        if (out_ready_i) begin
          capture = 1'b1;
          st_d    = TS_IDLE;
        end
      end
      default: st_d = TS_IDLE;
    endcase
  end

  // Lane requests; the lanes are cleared on the capture cycle itself
  always_comb begin
    full_req.start  = in_acc;
    full_req.absorb = 1'b1;
    full_req.clear  = 1'b0;
    full_req.data   = in_item_i.data_byte;
    tail_req.start  = in_acc;
    tail_req.absorb = ~skipping;
    tail_req.clear  = 1'b0;
    tail_req.data   = in_item_i.data_byte;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= TS_IDLE;
      skip_q      <= dfrd_pkg::SKIP_RESET;
      seen_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      if (cfg_we_i) begin
        skip_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        last_q <= in_item_i.last_byte;
        if (in_item_i.last_byte) begin
          seen_q <= '0;
        end else if (skipping) begin
          seen_q <= seen_q + 1'b1;
        end
      end
      if (capture) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_q.full_first_hash  <= full_first;
      out_q.full_second_hash <= full_second;
      out_q.tail_first_hash  <= tail_first;
      out_q.tail_second_hash <= tail_second;
    end
  end

  dfrd_pkg::lane_req_t full_req_c, tail_req_c;

  // Clear rides on the request at capture, while the lanes idle; the hashes
  // are read into the output register at the same edge
  always_comb begin
    full_req_c       = full_req;
    tail_req_c       = tail_req;
    full_req_c.clear = capture;
    tail_req_c.clear = capture;
  end

  dfrd_lane u_full (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (full_req_c),
    .done_o   (full_done),
    .first_o  (full_first),
    .second_o (full_second)
  );

  dfrd_lane u_tail (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tail_req_c),
    .done_o   (tail_done),
    .first_o  (tail_first),
    .second_o (tail_second)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The two lanes run in lock step
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_done == tail_done)
    else $error("hash lanes out of step");

  // Lane completion is only seen while a transaction is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_done |-> st_q == TS_BUSY)
    else $error("lane completion outside busy state");

  // Waiting for the output register implies it is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni) st_q == TS_HOLD |-> out_valid_q)
    else $error("holding result with free output register");

  // A skipped non-final byte advances the byte count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_item_i.last_byte && skipping |=> seen_q == $past(seen_q) + 1'b1)
    else $error("byte count did not advance");

  // A result is captured, and the lanes cleared, only while no byte can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) capture |-> !in_ready_o)
    else $error("clear overlaps a new byte");

endmodule
